// File: hw/rtl/next_fit_partition_allocator_macros.svh
// assertion macros for the next-fit partition allocator
`ifndef NEXT_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define NFPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/nfpa_pkg.sv
// package: types, codes and sizes of the next-fit partition allocator
package nfpa_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int TOT_W      = 20;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_REPORT = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_BAD    = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RD_OUT
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] amount;
        logic [7:0]  owner_tag;
        logic [3:0]  entry_select;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  block_index;
        logic [15:0] leftover;
        logic [7:0]  owner_id;
        logic [15:0] block_capacity;
        logic        block_taken;
        logic [19:0] internal_total;
        logic [19:0] external_total;
    } result_t;

    // one table row as held in the ram
    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] rem;
        logic [7:0]           owner;
    } entry_t;

endpackage

// File: hw/rtl/nfpa_ram.sv
// generic single-port ram with registered read
module nfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/nfpa_alu.sv
// shared adder: saturating accumulate or subtract with borrow
module nfpa_alu (
    input  nfpa_pkg::alu_op_t             op,
    input  logic [nfpa_pkg::TOT_W-1:0]    a,
    input  logic [nfpa_pkg::SIZE_BITS-1:0] b,
    output logic [nfpa_pkg::TOT_W-1:0]    y,
    output logic                          flag
);
    import nfpa_pkg::*;

    logic [TOT_W:0] b_ext;
    logic [TOT_W:0] b_opnd;
    logic [TOT_W:0] sum;

    assign b_ext  = {{(TOT_W + 1 - SIZE_BITS){1'b0}}, b};
    assign b_opnd = (op == ALU_SUB) ? ~b_ext : b_ext;
    assign sum    = {1'b0, a} + b_opnd + {{TOT_W{1'b0}}, (op == ALU_SUB)};

    // carry on add means overflow, top bit on subtract means borrow
    assign flag = sum[TOT_W];

    always_comb
    begin
        if (op == ALU_ADD && sum[TOT_W])
        begin
            y = '1;
        end
        else
        begin
            y = sum[TOT_W-1:0];
        end
    end

endmodule

// File: hw/rtl/next_fit_partition_allocator.sv
// top level: sequencer, partition table and shared adder of the allocator
//
// Command interface: drive cmd and raise start while busy is low; the
// transaction is taken at that clock edge. Each command gives exactly one
// result: done is high for one cycle with result valid, and the receiver
// must take it then, as there is no way to hold it off.
// Operations: load appends a partition, allocate grants the next unused
// partition that fits (next fit from the rotating pointer), report sums the
// internal and external fragmentation, read returns one table entry.
// Completion: load, a load into a full table and a read beyond the loaded
// entries give done in the cycle after start; a read of a loaded entry
// passes through S_RD_OUT, which takes the ram data into the result.
// Allocate and report walk the loaded entries through the single ram port
// and the shared adder one entry a cycle. busy is high for the walk.
// A new command may start in the cycle that done is shown.
// Reset clears the table count, the used flags, the scan pointer and the
// failure flag; the partition ram needs no clearing since an entry is
// read only once loaded.
module next_fit_partition_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  nfpa_pkg::cmd_t    cmd,
    output logic              done,
    output nfpa_pkg::result_t result
);
    import nfpa_pkg::*;

    `include "next_fit_partition_allocator_macros.svh"

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic                 failed_reg, failed_next;
    logic [MAX_BLOCKS-1:0] used_reg, used_next;
    logic                 pend_reg, pend_next;
    logic [CNT_W-1:0]     iss_reg, iss_next;
    logic                 done_reg, done_next;

    op_t                  op_reg, op_next;
    logic [SIZE_BITS-1:0] amount_reg, amount_next;
    logic [7:0]           tag_reg, tag_next;
    logic [IDX_W-1:0]     j_reg, j_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic [TOT_W-1:0]     itot_reg, itot_next;
    logic [TOT_W-1:0]     etot_reg, etot_next;
    result_t              result_reg, result_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    entry_t               ram_wdata;
    entry_t               ram_rdata;

    alu_op_t              alu_op;
    logic [TOT_W-1:0]     alu_a;
    logic [SIZE_BITS-1:0] alu_b;
    logic [TOT_W-1:0]     alu_y;
    logic                 alu_flag;

    logic                 p_used;
    logic                 hit;
    logic                 all_issued;
    logic [CNT_W-1:0]     j_inc;

    nfpa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    nfpa_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .y    (alu_y),
        .flag (alu_flag)
    );

    assign p_used     = used_reg[pidx_reg];
    assign all_issued = (iss_reg == count_reg);
    assign j_inc      = {1'b0, j_reg} + CNT_W'(1);

    // allocate subtracts the request from the row, report accumulates
    always_comb
    begin
        if (op_reg == OP_ALLOC)
        begin
            alu_op = ALU_SUB;
            alu_a  = TOT_W'(ram_rdata.rem);
            alu_b  = amount_reg;
        end
        else
        begin
            alu_op = ALU_ADD;
            alu_a  = p_used ? itot_reg : etot_reg;
            alu_b  = ram_rdata.rem;
        end
    end

    assign hit = (state_reg == S_SCAN) && (op_reg == OP_ALLOC) && pend_reg
                 && !p_used && !alu_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            failed_reg <= 1'b0;
            used_reg   <= '0;
            pend_reg   <= 1'b0;
            iss_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            failed_reg <= failed_next;
            used_reg   <= used_next;
            pend_reg   <= pend_next;
            iss_reg    <= iss_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        amount_reg <= amount_next;
        tag_reg    <= tag_next;
        j_reg      <= j_next;
        pidx_reg   <= pidx_next;
        itot_reg   <= itot_next;
        etot_reg   <= etot_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        failed_next = failed_reg;
        used_next   = used_reg;
        pend_next   = pend_reg;
        iss_next    = iss_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        amount_next = amount_reg;
        tag_next    = tag_reg;
        j_next      = j_reg;
        pidx_next   = pidx_reg;
        itot_next   = itot_reg;
        etot_next   = etot_reg;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_addr    = j_reg;
        ram_wdata   = ram_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.op;
                    amount_next = cmd.amount;
                    tag_next    = cmd.owner_tag;
                    pend_next   = 1'b0;
                    iss_next    = '0;
                    itot_next   = '0;
                    etot_next   = '0;
                    unique case (cmd.op)
                        OP_LOAD:
                        begin
                            result_next = '0;
                            done_next   = 1'b1;
                            if (count_reg == CNT_W'(MAX_BLOCKS))
                            begin
                                result_next.status = ST_BAD;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_addr        = count_reg[IDX_W-1:0];
                                ram_wdata.size  = cmd.amount;
                                ram_wdata.rem   = cmd.amount;
                                ram_wdata.owner = cmd.owner_tag;
                                used_next[count_reg[IDX_W-1:0]] = 1'b0;
                                count_next = count_reg + CNT_W'(1);
                                result_next.status         = ST_OK;
                                result_next.block_index    = 4'(count_reg[IDX_W-1:0]);
                                result_next.leftover       = cmd.amount;
                                result_next.block_capacity = cmd.amount;
                            end
                        end
                        OP_ALLOC:
                        begin
                            // a stale pointer restarts the walk at entry zero
                            j_next     = ({1'b0, ptr_reg} < count_reg) ? ptr_reg : '0;
                            state_next = S_SCAN;
                        end
                        OP_REPORT:
                        begin
                            j_next     = '0;
                            state_next = S_SCAN;
                        end
                        OP_READ:
                        begin
                            if (CNT_W'(cmd.entry_select) >= count_reg)
                            begin
                                result_next        = '0;
                                result_next.status = ST_BAD;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                ram_addr   = IDX_W'(cmd.entry_select);
                                pidx_next  = IDX_W'(cmd.entry_select);
                                state_next = S_RD_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // check the row read last cycle, issue the next one
                if (pend_reg && op_reg == OP_REPORT)
                begin
                    if (p_used)
                    begin
                        itot_next = alu_y;
                    end
                    else if (failed_reg)
                    begin
                        etot_next = alu_y;
                    end
                end

                if (hit)
                begin
                    ram_we          = 1'b1;
                    ram_addr        = pidx_reg;
                    ram_wdata.size  = ram_rdata.size;
                    ram_wdata.rem   = alu_y[SIZE_BITS-1:0];
                    ram_wdata.owner = tag_reg;
                    used_next[pidx_reg] = 1'b1;
                    ptr_next  = pidx_reg;
                    pend_next = 1'b0;
                    result_next                = '0;
                    result_next.status         = ST_OK;
                    result_next.block_index    = 4'(pidx_reg);
                    result_next.leftover       = alu_y[15:0];
                    result_next.owner_id       = tag_reg;
                    result_next.block_capacity = ram_rdata.size;
                    result_next.block_taken    = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (all_issued)
                begin
                    pend_next   = 1'b0;
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    if (op_reg == OP_ALLOC)
                    begin
                        result_next.status = ST_NO_FIT;
                        failed_next        = 1'b1;
                    end
                    else
                    begin
                        result_next.status         = ST_OK;
                        result_next.internal_total = itot_next;
                        result_next.external_total = etot_next;
                    end
                end
                else
                begin
                    ram_addr  = j_reg;
                    pend_next = 1'b1;
                    pidx_next = j_reg;
                    iss_next  = iss_reg + CNT_W'(1);
                    j_next    = (j_inc < count_reg) ? j_inc[IDX_W-1:0] : '0;
                end
            end

            S_RD_OUT:
            begin
                result_next                = '0;
                result_next.status         = ST_OK;
                result_next.block_index    = 4'(pidx_reg);
                result_next.leftover       = ram_rdata.rem;
                result_next.owner_id       = p_used ? ram_rdata.owner : 8'd0;
                result_next.block_capacity = ram_rdata.size;
                result_next.block_taken    = p_used;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `NFPA_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE,
        "result shown while the sequencer is still walking")
    `NFPA_ASSERT_NEXT(a_start_progress, clk, rst_n, start && !busy, busy || done,
        "accepted transaction neither completed nor held the block busy")
    `NFPA_ASSERT_NOW(a_taken_used, clk, rst_n, done_reg && result_reg.block_taken,
        used_reg[result_reg.block_index[IDX_W-1:0]],
        "reported taken block is not marked used")
    `NFPA_ASSERT_NOW(a_count_range, clk, rst_n, pend_reg, iss_reg <= count_reg,
        "walk issued more rows than are loaded")

endmodule

// File: sim/next_fit_partition_allocator_test.sv
// self-checking testbench for the next-fit partition allocator
module next_fit_partition_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nfpa_pkg::*;

    localparam int RANDOM_ITEMS = 730;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 24;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    cmd_t    pending_cmds[$];
    result_t expected_results[$];
    int      idle_left;
    int      quiet_cycles;
    int      n_errors = 0;
    int      n_checked = 0;

    // predictor copy of the partition table
    logic [15:0] tbl_size[MAX_BLOCKS];
    logic [15:0] tbl_rem[MAX_BLOCKS];
    logic [7:0]  tbl_owner[MAX_BLOCKS];
    logic        tbl_used[MAX_BLOCKS];
    int          tbl_count = 0;
    int          scan_ptr = 0;
    logic        any_fail = 1'b0;

    int n_loads = 0, n_full_loads = 0, n_grants = 0, n_no_fit = 0;
    int n_reports = 0, n_reads = 0, n_bad_reads = 0;

    next_fit_partition_allocator u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic result_t entry_view(int idx);
        result_t r;
        r = '0;
        r.status         = ST_OK;
        r.block_index    = idx[3:0];
        r.leftover       = tbl_rem[idx];
        r.owner_id       = tbl_used[idx] ? tbl_owner[idx] : 8'd0;
        r.block_capacity = tbl_size[idx];
        r.block_taken    = tbl_used[idx];
        return r;
    endfunction

    function automatic result_t predict_result(cmd_t c);
        result_t r;
        int      j;
        logic    hit;
        int      itot;
        int      etot;
        r = '0;
        case (c.op)
            OP_LOAD:
            begin
                n_loads++;
                if (tbl_count >= MAX_BLOCKS)
                begin
                    n_full_loads++;
                    r.status = ST_BAD;
                end
                else
                begin
                    tbl_size[tbl_count] = c.amount;
                    tbl_rem[tbl_count]  = c.amount;
                    tbl_used[tbl_count] = 1'b0;
                    r = entry_view(tbl_count);
                    tbl_count++;
                end
            end
            OP_ALLOC:
            begin
                // next fit: start at the pointer, wrap once around the loaded entries
                j = (scan_ptr < tbl_count) ? scan_ptr : 0;
                hit = 1'b0;
                for (int k = 0; k < tbl_count && !hit; k++)
                begin
                    if (!tbl_used[j] && c.amount <= tbl_rem[j])
                    begin
                        tbl_used[j]  = 1'b1;
                        tbl_rem[j]   = tbl_size[j] - c.amount;
                        tbl_owner[j] = c.owner_tag;
                        scan_ptr     = j;
                        hit          = 1'b1;
                    end
                    else
                        j = (j + 1 < tbl_count) ? j + 1 : 0;
                end
                if (hit)
                begin
                    n_grants++;
                    r = entry_view(j);
                end
                else
                begin
                    n_no_fit++;
                    any_fail = 1'b1;
                    r.status = ST_NO_FIT;
                end
            end
            OP_REPORT:
            begin
                n_reports++;
                itot = 0;
                etot = 0;
                for (int k = 0; k < tbl_count; k++)
                begin
                    if (tbl_used[k])
                        itot += tbl_rem[k];
                    else if (any_fail)
                        etot += tbl_rem[k];
                end
                r.internal_total = (itot > 20'hFFFFF) ? 20'hFFFFF : itot[19:0];
                r.external_total = (etot > 20'hFFFFF) ? 20'hFFFFF : etot[19:0];
            end
            default:
            begin
                n_reads++;
                if (c.entry_select >= tbl_count)
                begin
                    n_bad_reads++;
                    r.status = ST_BAD;
                end
                else
                    r = entry_view(c.entry_select);
            end
        endcase
        return r;
    endfunction

    task automatic add_cmd(op_t op, int amount, int tag, int sel);
        cmd_t c;
        c.op           = op;
        c.amount       = amount[15:0];
        c.owner_tag    = tag[7:0];
        c.entry_select = sel[3:0];
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on transaction %0d: %s got %0d expected %0d",
                 n_checked, field, got, want);
        n_errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // driver: next transaction goes out once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic taken;
        cmd_t nxt;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cmd       <= '0;
            idle_left = 0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
                expected_results = {expected_results, predict_result(cmd)};
            if (!start || taken)
            begin
                if (idle_left > 0 || pending_cmds.size() == 0)
                begin
                    if (idle_left > 0)
                        idle_left--;
                    start <= 1'b0;
                end
                else
                begin
                    nxt = pending_cmds.pop_front();
                    cmd   <= nxt;
                    start <= 1'b1;
                    idle_left = pick_gap();
                end
            end
        end
    end

    // monitor: results are compared in order
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result: status %0d index %0d",
                         int'(result.status), result.block_index);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", int'(result.status), int'(want.status));
                if (result.block_index !== want.block_index)
                    report_mismatch("block_index", int'(result.block_index),
                                    int'(want.block_index));
                if (result.leftover !== want.leftover)
                    report_mismatch("leftover", int'(result.leftover), int'(want.leftover));
                if (result.owner_id !== want.owner_id)
                    report_mismatch("owner_id", int'(result.owner_id), int'(want.owner_id));
                if (result.block_capacity !== want.block_capacity)
                    report_mismatch("block_capacity", int'(result.block_capacity),
                                    int'(want.block_capacity));
                if (result.block_taken !== want.block_taken)
                    report_mismatch("block_taken", int'(result.block_taken),
                                    int'(want.block_taken));
                if (result.internal_total !== want.internal_total)
                    report_mismatch("internal_total", int'(result.internal_total),
                                    int'(want.internal_total));
                if (result.external_total !== want.external_total)
                    report_mismatch("external_total", int'(result.external_total),
                                    int'(want.external_total));
                n_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int   sel;
        int   amount;
        op_t  op;

        // directed: empty table first, then extremes, wrap-around and failures
        add_cmd(OP_READ, 0, 0, 0);
        add_cmd(OP_ALLOC, 5, 8'h3C, 0);
        add_cmd(OP_REPORT, 0, 0, 0);
        add_cmd(OP_LOAD, 0, 0, 0);
        add_cmd(OP_LOAD, 65535, 0, 0);
        add_cmd(OP_LOAD, 100, 0, 0);
        add_cmd(OP_LOAD, 300, 0, 0);
        add_cmd(OP_READ, 0, 0, 3);
        add_cmd(OP_READ, 0, 0, 4);
        add_cmd(OP_ALLOC, 0, 8'hFF, 0);
        add_cmd(OP_ALLOC, 65535, 8'h00, 15);
        add_cmd(OP_ALLOC, 200, 8'hA5, 0);
        add_cmd(OP_ALLOC, 150, 8'h12, 0);
        add_cmd(OP_ALLOC, 100, 8'h5A, 0);
        add_cmd(OP_LOAD, 50, 0, 0);
        add_cmd(OP_REPORT, 65535, 8'hFF, 15);
        add_cmd(OP_READ, 0, 0, 1);
        add_cmd(OP_READ, 0, 0, 3);
        add_cmd(OP_READ, 65535, 8'hFF, 15);
        add_cmd(OP_ALLOC, 0, 8'h11, 0);
        add_cmd(OP_REPORT, 0, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
                op = OP_LOAD;
            else if (sel < 60)
                op = OP_ALLOC;
            else if (sel < 75)
                op = OP_REPORT;
            else
                op = OP_READ;
            case ($urandom_range(0, 7))
                0: amount = 0;
                1: amount = 65535;
                2, 3, 4: amount = $urandom_range(0, 65535);
                default: amount = $urandom_range(0, 4095);
            endcase
            add_cmd(op, amount, $urandom_range(0, 255), $urandom_range(0, 15));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d transactions: %0d loads (%0d into a full table),",
                 n_checked, n_loads, n_full_loads);
        $display("%0d grants, %0d allocations without fit, %0d fragmentation reports,",
                 n_grants, n_no_fit, n_reports);
        $display("%0d entry reads (%0d out of range)", n_reads, n_bad_reads);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
